/* sv/dau_pkg.sv */
package dau_pkg;

    localparam int unsigned DataW = 64;

    typedef enum logic [2:0] {
        OP_LOAD    = 3'd0,
        OP_ADD     = 3'd1,
        OP_SUB     = 3'd2,
        OP_MOD     = 3'd3,
        OP_MUL     = 3'd4,
        OP_DIV     = 3'd5,
        OP_COMPOSE = 3'd6,
        OP_COMPARE = 3'd7
    } t_opcode;

    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_OVF  = 2'd1;
    localparam logic [1:0] ERR_DIVZ = 2'd2;

    localparam logic [1:0] CMP_EQ = 2'd0;
    localparam logic [1:0] CMP_GT = 2'd1;
    localparam logic [1:0] CMP_LT = 2'd2;

    localparam logic [63:0] TICKS_PER_USEC = 64'd10;
    localparam logic [63:0] USEC_PER_SEC   = 64'd1000000;
    localparam logic [63:0] SEC_PER_MIN    = 64'd60;
    localparam logic [63:0] MIN_PER_HOUR   = 64'd60;
    localparam logic [63:0] HOUR_PER_DAY   = 64'd24;
    localparam logic [63:0] POS_LIMIT      = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_LIMIT      = 64'h8000_0000_0000_0000;

    localparam logic [6:0] MUL_LAST = 7'd31;
    localparam logic [6:0] DIV_LAST = 7'd63;
    localparam logic [2:0] STEP_LAST = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ARITH_GO,
        ST_ARITH_WAIT,
        ST_COMP_GO,
        ST_COMP_WAIT,
        ST_DEC_GO,
        ST_DEC_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [63:0] a;
        logic [63:0] b;
    } t_alu_req;

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic [63:0] with_sign(input logic [63:0] m, input logic neg);
        return neg ? (64'd0 - m) : m;
    endfunction

endpackage

/* sv/duration_accumulator_unit_top.sv */
// load/add/sub/compare go from request to result valid through five passes of the
// shared 64-step divider that split the value into days..microseconds
// mul adds a multiplier pass, mod/div add up to a divider pass, compose adds its multiply chain
// one request at a time: a new request is taken the cycle after the result is taken
// synchronous active-low reset clears the stored duration and normalize_enable
module duration_accumulator_unit_top import dau_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // opcode, operand, neg_in, day_in, hour_in, minute_in, second_in, usec_in, pad
    input  logic [167:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // value_out, neg_out, day_out, hour_out, minute_out, second_out, usec_out,
    // cmp_out, error_code, pad
    output logic [135:0] o_m_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [0:0]   i_cfg_data
);

    t_state      r_state, n_state;
    logic        r_norm;
    logic [63:0] r_value, n_value;
    logic [63:0] r_acc, n_acc;
    logic [2:0]  r_step, n_step;
    t_opcode     r_op, n_op;
    logic [63:0] r_opnd, n_opnd;
    logic        r_neg_in, n_neg_in;
    logic [15:0] r_hour, n_hour, r_min, n_min, r_sec, n_sec;
    logic [23:0] r_usec, n_usec;
    logic [1:0]  r_err, n_err, r_cmp, n_cmp;
    logic [23:0] r_day_o, n_day_o;
    logic [4:0]  r_hour_o, n_hour_o;
    logic [5:0]  r_min_o, n_min_o, r_sec_o, n_sec_o;
    logic [19:0] r_usec_o, n_usec_o;

    t_alu_req    alu_req;
    logic        alu_done;
    logic [95:0] alu_prod;
    logic [63:0] alu_quot, alu_rem;

    t_opcode     in_op;
    logic [63:0] in_opnd;
    logic [63:0] sum, dif, vmag, lim, comp_add, comp_k, dec_k;
    logic        bad_field;

    dau_alu u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (alu_req),
        .o_done (alu_done),
        .o_prod (alu_prod),
        .o_quot (alu_quot),
        .o_rem  (alu_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_value <= '0;
            r_norm  <= 1'b0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_value <= n_value;
            r_step  <= n_step;
            if (i_cfg_valid) begin
                r_norm <= i_cfg_data[0];
            end
        end
        r_acc    <= n_acc;
        r_op     <= n_op;
        r_opnd   <= n_opnd;
        r_neg_in <= n_neg_in;
        r_hour   <= n_hour;
        r_min    <= n_min;
        r_sec    <= n_sec;
        r_usec   <= n_usec;
        r_err    <= n_err;
        r_cmp    <= n_cmp;
        r_day_o  <= n_day_o;
        r_hour_o <= n_hour_o;
        r_min_o  <= n_min_o;
        r_sec_o  <= n_sec_o;
        r_usec_o <= n_usec_o;
    end

    always_comb begin
        in_op   = t_opcode'(i_s_tdata[2:0]);
        in_opnd = i_s_tdata[66:3];
        vmag    = mag64(r_value);
        sum     = r_value + in_opnd;
        dif     = r_value - in_opnd;
        bad_field = (i_s_tdata[107:92] >= HOUR_PER_DAY[15:0])
                 || (i_s_tdata[123:108] >= MIN_PER_HOUR[15:0])
                 || (i_s_tdata[139:124] >= SEC_PER_MIN[15:0])
                 || (i_s_tdata[163:140] >= USEC_PER_SEC[23:0]);
        lim = (r_op == OP_COMPOSE ? r_neg_in : r_value[63]) ? NEG_LIMIT : POS_LIMIT;

        case (r_step)
            3'd0:    begin comp_k = HOUR_PER_DAY;   comp_add = {48'd0, r_hour}; end
            3'd1:    begin comp_k = MIN_PER_HOUR;   comp_add = {48'd0, r_min};  end
            3'd2:    begin comp_k = SEC_PER_MIN;    comp_add = {48'd0, r_sec};  end
            3'd3:    begin comp_k = USEC_PER_SEC;   comp_add = {40'd0, r_usec}; end
            default: begin comp_k = TICKS_PER_USEC; comp_add = 64'd0;           end
        endcase
        case (r_step)
            3'd0:    dec_k = TICKS_PER_USEC;
            3'd1:    dec_k = USEC_PER_SEC;
            3'd2:    dec_k = SEC_PER_MIN;
            3'd3:    dec_k = MIN_PER_HOUR;
            default: dec_k = HOUR_PER_DAY;
        endcase

        n_state  = r_state;
        n_value  = r_value;
        n_acc    = r_acc;
        n_step   = r_step;
        n_op     = r_op;
        n_opnd   = r_opnd;
        n_neg_in = r_neg_in;
        n_hour   = r_hour;
        n_min    = r_min;
        n_sec    = r_sec;
        n_usec   = r_usec;
        n_err    = r_err;
        n_cmp    = r_cmp;
        n_day_o  = r_day_o;
        n_hour_o = r_hour_o;
        n_min_o  = r_min_o;
        n_sec_o  = r_sec_o;
        n_usec_o = r_usec_o;
        alu_req  = '{start: 1'b0, is_div: 1'b0, a: 64'd0, b: 64'd0};

        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_op     = in_op;
                    n_opnd   = in_opnd;
                    n_neg_in = i_s_tdata[67];
                    n_hour   = i_s_tdata[107:92];
                    n_min    = i_s_tdata[123:108];
                    n_sec    = i_s_tdata[139:124];
                    n_usec   = i_s_tdata[163:140];
                    n_err    = ERR_OK;
                    n_cmp    = CMP_EQ;
                    n_step   = '0;
                    n_acc    = vmag;
                    n_state  = ST_DEC_GO;
                    unique case (in_op)
                        OP_LOAD: begin
                            n_value = in_opnd;
                            n_acc   = mag64(in_opnd);
                        end
                        OP_ADD: begin
                            if ((r_value[63] ^ sum[63]) & (in_opnd[63] ^ sum[63])) begin
                                n_err = ERR_OVF;
                            end else begin
                                n_value = sum;
                                n_acc   = mag64(sum);
                            end
                        end
                        OP_SUB: begin
                            if ((r_value[63] ^ in_opnd[63]) & (r_value[63] ^ dif[63])) begin
                                n_err = ERR_OVF;
                            end else begin
                                n_value = dif;
                                n_acc   = mag64(dif);
                            end
                        end
                        OP_MOD: begin
                            if (in_opnd == 64'd0) n_err = ERR_DIVZ;
                            else n_state = ST_ARITH_GO;
                        end
                        OP_DIV: begin
                            if (in_opnd[31:0] == 32'd0) n_err = ERR_DIVZ;
                            else n_state = ST_ARITH_GO;
                        end
                        OP_MUL: n_state = ST_ARITH_GO;
                        OP_COMPOSE: begin
                            if (!r_norm && bad_field) begin
                                n_err = ERR_OVF;
                            end else begin
                                n_acc   = {40'd0, i_s_tdata[91:68]};
                                n_state = ST_COMP_GO;
                            end
                        end
                        OP_COMPARE: begin
                            if ($signed(in_opnd) > $signed(r_value)) n_cmp = CMP_GT;
                            else if ($signed(in_opnd) < $signed(r_value)) n_cmp = CMP_LT;
                        end
                        default: n_state = ST_DEC_GO;
                    endcase
                end
            end
            ST_ARITH_GO: begin
                alu_req.start  = 1'b1;
                alu_req.is_div = (r_op != OP_MUL);
                alu_req.a      = vmag;
                alu_req.b      = (r_op == OP_MOD) ? mag64(r_opnd) : {32'd0, r_opnd[31:0]};
                n_state = ST_ARITH_WAIT;
            end
            ST_ARITH_WAIT: begin
                if (alu_done) begin
                    n_state = ST_DEC_GO;
                    if (r_op == OP_MUL) begin
                        if (alu_prod > {32'd0, lim}) begin
                            n_err = ERR_OVF;
                        end else begin
                            n_value = with_sign(alu_prod[63:0], r_value[63]);
                            n_acc   = alu_prod[63:0];
                        end
                    end else if (r_op == OP_MOD) begin
                        n_value = with_sign(alu_rem, r_value[63]);
                        n_acc   = alu_rem;
                    end else begin
                        n_value = with_sign(alu_quot, r_value[63]);
                        n_acc   = alu_quot;
                    end
                end
            end
            ST_COMP_GO: begin
                alu_req.start = 1'b1;
                alu_req.a     = r_acc;
                alu_req.b     = comp_k;
                n_state = ST_COMP_WAIT;
            end
            ST_COMP_WAIT: begin
                if (alu_done) begin
                    if (r_step == STEP_LAST) begin
                        n_step  = '0;
                        n_state = ST_DEC_GO;
                        if (alu_prod[63:0] > lim) begin
                            n_err = ERR_OVF;
                            n_acc = vmag;
                        end else begin
                            n_value = with_sign(alu_prod[63:0], r_neg_in);
                            n_acc   = alu_prod[63:0];
                        end
                    end else begin
                        n_acc   = alu_prod[63:0] + comp_add;
                        n_step  = r_step + 3'd1;
                        n_state = ST_COMP_GO;
                    end
                end
            end
            ST_DEC_GO: begin
                alu_req.start  = 1'b1;
                alu_req.is_div = 1'b1;
                alu_req.a      = r_acc;
                alu_req.b      = dec_k;
                n_state = ST_DEC_WAIT;
            end
            ST_DEC_WAIT: begin
                if (alu_done) begin
                    n_acc  = alu_quot;
                    n_step = r_step + 3'd1;
                    n_state = ST_DEC_GO;
                    case (r_step)
                        3'd1: n_usec_o = alu_rem[19:0];
                        3'd2: n_sec_o  = alu_rem[5:0];
                        3'd3: n_min_o  = alu_rem[5:0];
                        3'd4: begin
                            n_hour_o = alu_rem[4:0];
                            n_day_o  = alu_quot[23:0];
                            n_step   = '0;
                            n_state  = ST_OUT;
                        end
                        default: n_acc = alu_quot;
                    endcase
                end
            end
            ST_OUT: begin
                if (i_m_tready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_m_tvalid  = (r_state == ST_OUT);
    assign o_cfg_ready = 1'b1;
    assign o_m_tdata   = {6'd0, r_err, r_cmp, r_usec_o, r_sec_o, r_min_o, r_hour_o,
                          r_day_o, r_value[63], r_value};

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("input taken while result pending");
    a_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_done |-> (r_state == ST_ARITH_WAIT || r_state == ST_COMP_WAIT
                      || r_state == ST_DEC_WAIT))
        else $error("unit finished with nobody waiting");
    a_divz_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_err == ERR_DIVZ) |-> (r_op == OP_MOD || r_op == OP_DIV))
        else $error("divide by zero flagged on wrong opcode");
    a_err_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ARITH_WAIT && alu_done && r_op == OP_MUL
         && alu_prod > {32'd0, lim}) |=> $stable(r_value))
        else $error("overflowing multiply changed the value");

endmodule

/* sv/dau_alu.sv */
module dau_alu import dau_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_alu_req    i_req,
    output logic        o_done,
    output logic [95:0] o_prod,
    output logic [63:0] o_quot,
    output logic [63:0] o_rem
);

    logic        r_busy, n_busy;
    logic        r_is_div, n_is_div;
    logic        r_done, n_done;
    logic [6:0]  r_cnt, n_cnt;
    logic [63:0] r_a, n_a;
    logic [63:0] r_b, n_b;
    logic [95:0] r_prod, n_prod;
    logic [63:0] r_quot, n_quot;
    logic [63:0] r_rem, n_rem;

    logic [64:0] mul_sum;
    logic [64:0] shifted;
    logic [65:0] diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_is_div <= n_is_div;
        r_a      <= n_a;
        r_b      <= n_b;
        r_prod   <= n_prod;
        r_quot   <= n_quot;
        r_rem    <= n_rem;
    end

    always_comb begin
        // shift-add multiply step and restoring divide step share the sequencing
        mul_sum = {1'b0, r_prod[95:32]} + (r_prod[0] ? {1'b0, r_a} : 65'd0);
        shifted = {r_rem, r_quot[63]};
        diff    = {1'b0, shifted} - {2'b00, r_b};
        n_busy   = r_busy;
        n_is_div = r_is_div;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_a      = r_a;
        n_b      = r_b;
        n_prod   = r_prod;
        n_quot   = r_quot;
        n_rem    = r_rem;
        if (!r_busy) begin
            if (i_req.start) begin
                n_busy   = 1'b1;
                n_is_div = i_req.is_div;
                n_cnt    = '0;
                n_a      = i_req.a;
                n_b      = i_req.b;
                n_prod   = {64'd0, i_req.b[31:0]};
                n_quot   = i_req.a;
                n_rem    = '0;
            end
        end else begin
            n_cnt = r_cnt + 7'd1;
            if (r_is_div) begin
                if (!diff[65]) begin
                    n_rem  = diff[63:0];
                    n_quot = {r_quot[62:0], 1'b1};
                end else begin
                    n_rem  = shifted[63:0];
                    n_quot = {r_quot[62:0], 1'b0};
                end
                if (r_cnt == DIV_LAST) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
            end else begin
                n_prod = {mul_sum, r_prod[31:1]};
                if (r_cnt == MUL_LAST) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule
